@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker of the beat detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbd: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbd: next-cycle property failed");

`endif

@@ design/pbd_pkg.sv @@
// Shared types and constants of the pulse beat detector.
`default_nettype none

package pbd_pkg;

    localparam int QUO_W     = 16;
    localparam int CFG_W     = 12;
    localparam int SAMPLE_W  = 12;
    localparam int ELAPSED_W = 16;
    localparam int DIV5_SHIFT = 18;

    localparam logic [31:0] NOISE_GUARD_MS   = 32'd250;
    localparam logic [31:0] TIMEOUT_MS       = 32'd2500;
    localparam logic [15:0] MS_PER_MINUTE    = 16'd60000;
    localparam logic [15:0] RESET_INTERVAL   = 16'd750;
    localparam logic [15:0] TIMEOUT_INTERVAL = 16'd600;
    localparam logic [15:0] MID_LEVEL        = 16'd600;
    localparam logic [15:0] START_AMPLITUDE  = 16'd120;
    // floor(x / 5) == (x * 0xCCCD) >> 18 for every 16-bit x
    localparam logic [15:0] DIV5_MAGIC       = 16'd52429;
    localparam logic [7:0]  RATE_MAX         = 8'd255;

    typedef struct packed {
        logic     accept;
        logic     calc;
        logic     eval;
        logic     cfg_we;
        logic     div_start;
        logic     mean_load;
        logic     rate_load;
        logic     rate_zero;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic mean_zero;
    } t_sts;

endpackage

`default_nettype wire

@@ design/pbd_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, QW-bit quotient.
`default_nettype none

module pbd_div #(
    parameter int DW = 20,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [QW-1:0]      o_quotient
);

    localparam int CW = $clog2(QW);

    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          fits;

    // The quotient is known to fit QW bits, so the upper dividend bits start
    // as the partial remainder and only QW steps are needed.
    assign shifted = {r_rem, r_quo[QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign fits    = ~diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend >> QW;
            r_quo <= i_dividend[QW-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ design/pbd_dpath.sv @@
// Datapath: detector state, beat evaluation, interval history and division.
`default_nettype none

module pbd_dpath #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pbd_pkg::t_cmd                   i_cmd,
    output pbd_pkg::t_sts                        o_sts,
    input  wire logic [pbd_pkg::SAMPLE_W-1:0]    i_sample_mv,
    input  wire logic [pbd_pkg::ELAPSED_W-1:0]   i_elapsed_ms,
    input  wire logic [pbd_pkg::CFG_W-1:0]       i_cfg_data,
    output logic [7:0]                           o_beats_per_minute,
    output logic [15:0]                          o_interval_ms,
    output logic                                 o_beat_started,
    output logic                                 o_inside_beat,
    output logic [11:0]                          o_pulse_amplitude,
    output logic [31:0]                          o_last_beat_ms
);

    localparam int LW    = SAMPLE_BITS;
    localparam int SUM_W = 16 + $clog2(HISTORY_DEPTH);
    localparam int QW    = pbd_pkg::QUO_W;

    // floor(sum / depth) as (sum * ceil(2^(SUM_W+L) / depth)) >> (SUM_W+L),
    // exact for every SUM_W-bit sum when L = ceil(log2(depth))
    localparam int RECIP_L = $clog2(HISTORY_DEPTH);
    localparam int RECIP_S = SUM_W + RECIP_L;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << RECIP_S) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH);
    localparam logic [SUM_W:0] RECIP_M = (SUM_W+1)'(RECIP_FULL);

    // detector state
    logic [LW-1:0] r_setting, r_thr, r_peak, r_trough, r_amp;
    logic [31:0]   r_tc, r_lbs;
    logic [15:0]   r_interval;
    logic          r_pulse, r_af, r_as, r_bflag;
    logic [7:0]    r_rate;
    logic [15:0]   r_hist [HISTORY_DEPTH];
    logic [SUM_W-1:0] r_sum;

    // per-sample working registers
    logic [LW-1:0] r_sample;
    logic [31:0]   r_prod;
    logic [31:0]   r_since;
    logic [15:0]   r_guard;
    logic [15:0]   r_mean;

    // result beat
    logic [7:0]    r_o_rate;
    logic [15:0]   r_o_interval;
    logic          r_o_bflag, r_o_pulse;
    logic [11:0]   r_o_amp;
    logic [31:0]   r_o_lbs;

    // next values from the evaluation step
    logic [LW-1:0] n_thr, n_peak, n_trough, n_amp;
    logic [31:0]   n_lbs;
    logic [15:0]   n_interval;
    logic          n_pulse, n_af, n_as, n_bflag;
    logic [7:0]    n_rate;

    logic [13:0]   q5;
    logic          below, above, long_since, beat, first, eob, tmo;
    logic [15:0]   iv_sat;
    logic [2*SUM_W:0] mean_prod;
    logic [SUM_W-1:0] div_dividend, div_divisor;
    logic          div_done;
    logic [QW-1:0] div_quo;

    assign q5 = r_prod[31:pbd_pkg::DIV5_SHIFT];

    assign below      = r_sample < r_thr;
    assign above      = r_sample > r_thr;
    assign long_since = r_since > 32'(r_guard);
    assign beat       = (r_since > pbd_pkg::NOISE_GUARD_MS) && above && !r_pulse && long_since;
    assign first      = beat && r_af;
    assign eob        = below && r_pulse;
    // the step that drops the first interval skips the timeout check
    assign tmo        = (r_since > pbd_pkg::TIMEOUT_MS) && !first;
    assign iv_sat     = (r_since[31:16] != 16'd0) ? 16'hFFFF : r_since[15:0];

    assign mean_prod  = (2*SUM_W+1)'(r_sum) * (2*SUM_W+1)'(RECIP_M);

    always_comb begin
        n_thr      = r_thr;
        n_peak     = r_peak;
        n_trough   = r_trough;
        n_amp      = r_amp;
        n_lbs      = r_lbs;
        n_interval = r_interval;
        n_pulse    = r_pulse;
        n_af       = r_af;
        n_as       = r_as;
        n_bflag    = r_bflag;
        n_rate     = r_rate;

        if (below && long_since && (r_sample < r_trough)) begin
            n_trough = r_sample;
        end
        if (above && (r_sample > r_peak)) begin
            n_peak = r_sample;
        end
        if (beat) begin
            n_pulse    = 1'b1;
            n_interval = iv_sat;
            n_lbs      = r_tc;
            if (r_af) begin
                n_af = 1'b0;
                n_as = 1'b1;
            end else begin
                n_as    = 1'b0;
                n_bflag = 1'b1;
            end
        end
        // re-center the threshold between peak and trough at the end of a beat
        if (eob) begin
            n_pulse  = 1'b0;
            n_amp    = n_peak - n_trough;
            n_thr    = n_trough + (n_amp >> 1);
            n_peak   = n_thr;
            n_trough = n_thr;
        end
        // re-arm after a long gap
        if (tmo) begin
            n_thr      = r_setting;
            n_peak     = LW'(pbd_pkg::MID_LEVEL);
            n_trough   = LW'(pbd_pkg::MID_LEVEL);
            n_lbs      = r_tc;
            n_af       = 1'b1;
            n_as       = 1'b0;
            n_bflag    = 1'b0;
            n_rate     = 8'd0;
            n_interval = pbd_pkg::TIMEOUT_INTERVAL;
            n_pulse    = 1'b0;
            n_amp      = LW'(pbd_pkg::START_AMPLITUDE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting  <= LW'(pbd_pkg::MID_LEVEL);
            r_thr      <= LW'(pbd_pkg::MID_LEVEL);
            r_peak     <= LW'(pbd_pkg::MID_LEVEL);
            r_trough   <= LW'(pbd_pkg::MID_LEVEL);
            r_amp      <= LW'(pbd_pkg::START_AMPLITUDE);
            r_tc       <= 32'd0;
            r_lbs      <= 32'd0;
            r_interval <= pbd_pkg::RESET_INTERVAL;
            r_pulse    <= 1'b0;
            r_af       <= 1'b1;
            r_as       <= 1'b0;
            r_bflag    <= 1'b0;
            r_rate     <= 8'd0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_setting <= LW'(i_cfg_data);
                r_thr     <= LW'(i_cfg_data);
            end else if (i_cmd.eval) begin
                r_thr <= n_thr;
            end
            if (i_cmd.accept) begin
                r_tc <= r_tc + 32'(i_elapsed_ms);
            end
            if (i_cmd.eval) begin
                r_peak     <= n_peak;
                r_trough   <= n_trough;
                r_amp      <= n_amp;
                r_lbs      <= n_lbs;
                r_interval <= n_interval;
                r_pulse    <= n_pulse;
                r_af       <= n_af;
                r_as       <= n_as;
                r_bflag    <= n_bflag;
            end
            priority if (i_cmd.eval) begin
                r_rate <= n_rate;
            end else if (i_cmd.rate_zero) begin
                r_rate <= 8'd0;
            end else if (i_cmd.rate_load) begin
                r_rate <= (div_quo[QW-1:8] != '0) ? pbd_pkg::RATE_MAX : div_quo[7:0];
            end else begin
                r_rate <= r_rate;
            end
        end
    end

    // interval history: oldest entry at index 0, running sum kept alongside
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && beat && !r_af) begin
            if (r_as) begin
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    r_hist[i] <= iv_sat;
                end
                r_sum <= SUM_W'(iv_sat) * SUM_W'(HISTORY_DEPTH);
            end else begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[HISTORY_DEPTH-1] <= iv_sat;
                r_sum <= r_sum - SUM_W'(r_hist[0]) + SUM_W'(iv_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= LW'(i_sample_mv);
            r_prod   <= {16'd0, r_interval} * {16'd0, pbd_pkg::DIV5_MAGIC};
        end
        if (i_cmd.calc) begin
            r_since <= r_tc - r_lbs;
            r_guard <= {1'b0, q5, 1'b0} + {2'b00, q5};
        end
        if (i_cmd.mean_load) begin
            r_mean <= mean_prod[RECIP_S +: 16];
        end
        if (i_cmd.out_load) begin
            r_o_rate     <= r_rate;
            r_o_interval <= r_interval;
            r_o_bflag    <= r_bflag;
            r_o_pulse    <= r_pulse;
            r_o_amp      <= 12'(r_amp);
            r_o_lbs      <= r_lbs;
        end
    end

    assign div_dividend = SUM_W'(pbd_pkg::MS_PER_MINUTE);
    assign div_divisor  = SUM_W'(r_mean);

    pbd_div #(
        .DW (SUM_W),
        .QW (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_sts.need_div  = beat && !first && !tmo;
    assign o_sts.div_done  = div_done;
    assign o_sts.mean_zero = (r_mean == 16'd0);

    assign o_beats_per_minute = r_o_rate;
    assign o_interval_ms      = r_o_interval;
    assign o_beat_started     = r_o_bflag;
    assign o_inside_beat      = r_o_pulse;
    assign o_pulse_amplitude  = r_o_amp;
    assign o_last_beat_ms     = r_o_lbs;

endmodule

`default_nettype wire

@@ design/pbd_ctrl.sv @@
// Controller: sequences one sample through evaluation, division and output.
`default_nettype none

module pbd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire pbd_pkg::t_sts i_sts,
    output pbd_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_CALC  = 7'b000_0010,
        S_EVAL  = 7'b000_0100,
        S_MEAN  = 7'b000_1000,
        S_RATE  = 7'b001_0000,
        S_RWAIT = 7'b010_0000,
        S_LOAD  = 7'b100_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   idle, out_free;

    assign idle     = (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cfg_we = i_cfg_valid;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_div ? S_MEAN : S_LOAD;
            end
            S_MEAN: begin
                o_cmd.mean_load = 1'b1;
                n_state         = S_RATE;
            end
            S_RATE: begin
                if (i_sts.mean_zero) begin
                    o_cmd.rate_zero = 1'b1;
                    n_state         = S_LOAD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.rate_load = 1'b1;
                    n_state         = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = o_cmd.out_load | (r_ovalid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall     = !idle;
    assign o_cfg_ready = idle;
    assign o_valid     = r_ovalid;

endmodule

`default_nettype wire

@@ design/pulse_beat_detector.sv @@
// Top level of the pulse beat detector: controller plus datapath.
// Pulse beat detector. Each input beat carries one sensor sample (mV) and the
// milliseconds since the previous sample; each one yields exactly one result
// beat with the averaged rate, last interval, beat flags, pulse amplitude and
// the time stamp of the last beat. One sample is processed at a time: a
// sample that does not complete a counted beat passes through the calc,
// eval and load steps; a counted beat also forms the mean interval, which
// is one reciprocal multiply, and unless that mean is zero runs the 16-step
// radix-2 divider that forms 60000 over it. The result sits in an output
// register; a stalled result holds the next sample only in its final step,
// not at acceptance. The threshold register is written over the config port
// while the block is idle and also reloads the live threshold at once.
`default_nettype none

module pulse_beat_detector #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [11:0] i_sample_mv,
    input  wire logic [15:0] i_elapsed_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_beats_per_minute,
    output logic [15:0]      o_interval_ms,
    output logic             o_beat_started,
    output logic             o_inside_beat,
    output logic [11:0]      o_pulse_amplitude,
    output logic [31:0]      o_last_beat_ms,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [11:0] i_cfg_data
);

    pbd_pkg::t_cmd cmd;
    pbd_pkg::t_sts sts;

    pbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pbd_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_sample_mv        (i_sample_mv),
        .i_elapsed_ms       (i_elapsed_ms),
        .i_cfg_data         (i_cfg_data),
        .o_beats_per_minute (o_beats_per_minute),
        .o_interval_ms      (o_interval_ms),
        .o_beat_started     (o_beat_started),
        .o_inside_beat      (o_inside_beat),
        .o_pulse_amplitude  (o_pulse_amplitude),
        .o_last_beat_ms     (o_last_beat_ms)
    );

endmodule

`default_nettype wire

@@ design/pbd_checker.sv @@
// Port-level checker for the pulse beat detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pbd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_beats_per_minute,
    input wire logic        o_beat_started,
    input wire logic [31:0] o_last_beat_ms
);

    // a nonzero rate only exists once a beat has been counted
    `PBD_ASSERT_HOLDS(a_rate_needs_beat, i_clk, i_rst_n, o_valid && (o_beats_per_minute != 8'd0), o_beat_started)

    // one sample at a time: after acceptance the input side is busy
    `PBD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    `PBD_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    `PBD_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, o_valid && i_stall, $stable(o_beats_per_minute) && $stable(o_last_beat_ms))

endmodule

bind pulse_beat_detector pbd_checker u_pbd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_beats_per_minute (o_beats_per_minute),
    .o_beat_started     (o_beat_started),
    .o_last_beat_ms     (o_last_beat_ms)
);

`default_nettype wire
